// ===== src/sqa_pkg.sv =====
`default_nettype none

package sqa_pkg;

    // interval and sample geometry
    localparam int MAX_LENGTH = 4096;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 13;
    localparam int RND_W      = 4;
    localparam int PIECES     = 12;
    localparam int QUADS      = 4;
    localparam int QUAD_W     = $clog2(QUADS);
    localparam int PIECE_W    = $clog2(PIECES);
    // boundaries and the per-frame threshold stay below this bound
    localparam int BND_W      = $clog2(PIECES * MAX_LENGTH + 16);

    localparam int IN_FIELDS_W = LEN_W + RND_W + 3 * SAMPLE_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int QCNT_W     = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_FRAME = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    // one quadrant accumulator, sum_a in the low bits
    typedef struct packed {
        logic [CNT_W-1:0] frame_count;
        logic [SUM_W-1:0] sum_c;
        logic [SUM_W-1:0] sum_b;
        logic [SUM_W-1:0] sum_a;
    } t_entry;

    localparam int ENTRY_W    = $bits(t_entry);
    localparam int OUT_DATA_W = ((ENTRY_W + 7) / 8) * 8;

    typedef struct packed {
        logic              last;
        logic [QUAD_W-1:0] quadrant;
        t_entry            entry;
    } t_result;

    typedef struct packed {
        logic              take;
        logic [QUAD_W-1:0] quadrant;
    } t_frame_info;

endpackage

`default_nettype wire

// ===== src/square_wave_quadrant_accumulator.sv =====
`default_nettype none

// channel   dir  signals                      contents
// s_axis    in   tvalid tready tdata tuser    one command transaction per item
// m_axis    out  tvalid tready tdata tuser    one quadrant report per transaction
//                tlast
//
// frame, clear and begin transactions are taken one per cycle while no read is
// in progress; a frame is read from the quadrant ram in its accept cycle and
// written back in the next cycle; a read holds s_axis_tready low from the cycle
// after its accept until it has issued one ram read per quadrant; reports leave
// through a two-entry output queue, the first one valid once its ram read has
// returned and been pushed; reset (synchronous, active low) zeroes every sum
// and count through per-entry valid bits, so no clearing pass is needed; clear
// does the same; a stalled m_axis holds back the quadrant reads once the queue has
// no room, keeping s_axis_tready low longer; accepted frames never wait on m_axis

module square_wave_quadrant_accumulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // interval_length, rounding, sample_a, sample_b, sample_c, zero fill
    input  logic [sqa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sum_a, sum_b, sum_c, frame_count
    output logic [sqa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // quadrant
    output logic [sqa_pkg::QUAD_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast
);

    import sqa_pkg::*;

    // input field slices
    t_action             act;
    logic [LEN_W-1:0]    in_len;
    logic [RND_W-1:0]    in_rnd;
    logic [SAMPLE_W-1:0] in_a;
    logic [SAMPLE_W-1:0] in_b;
    logic [SAMPLE_W-1:0] in_c;

    assign act    = t_action'(s_axis_tuser);
    assign in_len = s_axis_tdata[LEN_W-1:0];
    assign in_rnd = s_axis_tdata[LEN_W +: RND_W];
    assign in_a   = s_axis_tdata[LEN_W + RND_W +: SAMPLE_W];
    assign in_b   = s_axis_tdata[LEN_W + RND_W + SAMPLE_W +: SAMPLE_W];
    assign in_c   = s_axis_tdata[LEN_W + RND_W + 2 * SAMPLE_W +: SAMPLE_W];

    logic in_accept;
    logic do_clear;
    logic do_begin;
    logic do_frame;
    logic do_read;

    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign do_clear  = in_accept && (act == ACT_CLEAR);
    assign do_begin  = in_accept && (act == ACT_BEGIN);
    assign do_frame  = in_accept && (act == ACT_FRAME);
    assign do_read   = in_accept && (act == ACT_READ);

    // interval tracking: which quadrant the current frame lands in
    t_frame_info info;

    sqa_piece u_piece (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_begin    (do_begin),
        .i_frame    (do_frame),
        .i_length   (in_len),
        .i_rounding (in_rnd),
        .o_info     (info)
    );

    // read sequencer state
    logic              r_rd_busy;
    logic [QUAD_W-1:0] r_rd_q;
    logic              r_rd_pend;
    logic [QUAD_W-1:0] r_rd_pq;
    logic              rd_issue;

    // output queue status
    logic [QCNT_W-1:0] q_count;
    logic              q_pop;

    assign s_axis_tready = !r_rd_busy;

    // issue the next quadrant read only when the queue can still hold it
    assign rd_issue = r_rd_busy &&
        (({1'b0, q_count} + (QCNT_W + 1)'(r_rd_pend)) <=
         ((QCNT_W + 1)'(OUTQ_DEPTH - 1) + (QCNT_W + 1)'(q_pop)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_busy <= 1'b0;
            r_rd_q    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= rd_issue;
            if (do_read) begin
                r_rd_busy <= 1'b1;
                r_rd_q    <= '0;
            end else if (rd_issue) begin
                r_rd_q <= r_rd_q + 1'b1;
                if (r_rd_q == QUAD_W'(QUADS - 1)) begin
                    r_rd_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_pq <= r_rd_q;
        end
    end

    // frame stage: samples wait here while the ram returns the old entry
    logic                r_acc_vld;
    logic [QUAD_W-1:0]   r_acc_q;
    logic [SAMPLE_W-1:0] r_acc_a;
    logic [SAMPLE_W-1:0] r_acc_b;
    logic [SAMPLE_W-1:0] r_acc_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= 1'b0;
        end else begin
            r_acc_vld <= info.take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (info.take) begin
            r_acc_q <= info.quadrant;
            r_acc_a <= in_a;
            r_acc_b <= in_b;
            r_acc_c <= in_c;
        end
    end

    // quadrant ram, one entry per quadrant
    logic [ENTRY_W-1:0] ram_rd_data;
    logic               ram_rd_en;
    logic [QUAD_W-1:0]  ram_rd_addr;
    t_entry             n_entry;

    assign ram_rd_en   = info.take | rd_issue;
    assign ram_rd_addr = info.take ? info.quadrant : r_rd_q;

    sqa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUADS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_acc_vld),
        .i_wr_addr (r_acc_q),
        .i_wr_data (n_entry),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // valid bits: an entry not written since the last clear reads as zero
    logic [QUADS-1:0] r_valid;

    // last write, forwarded to a read of the same entry that returns in the next cycle
    logic              r_wr_vld;
    logic [QUAD_W-1:0] r_wr_q;
    t_entry            r_wr_data;

    logic [QUAD_W-1:0] sel_q;
    t_entry            old_entry;

    // the frame stage and a returning quadrant read never share a cycle
    assign sel_q = r_acc_vld ? r_acc_q : r_rd_pq;

    always_comb begin
        if (r_wr_vld && (r_wr_q == sel_q)) begin
            old_entry = r_wr_data;
        end else if (r_valid[sel_q]) begin
            old_entry = t_entry'(ram_rd_data);
        end else begin
            old_entry = '0;
        end
    end

    // sign-extended samples, wrapping sums and count
    always_comb begin
        n_entry.sum_a = old_entry.sum_a +
            {{(SUM_W - SAMPLE_W){r_acc_a[SAMPLE_W-1]}}, r_acc_a};
        n_entry.sum_b = old_entry.sum_b +
            {{(SUM_W - SAMPLE_W){r_acc_b[SAMPLE_W-1]}}, r_acc_b};
        n_entry.sum_c = old_entry.sum_c +
            {{(SUM_W - SAMPLE_W){r_acc_c[SAMPLE_W-1]}}, r_acc_c};
        n_entry.frame_count = old_entry.frame_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= r_acc_vld & ~do_clear;
            if (do_clear) begin
                r_valid <= '0;
            end else if (r_acc_vld) begin
                r_valid[r_acc_q] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_acc_vld) begin
            r_wr_q    <= r_acc_q;
            r_wr_data <= n_entry;
        end
    end

    // quadrant reports
    t_result push_data;
    t_result head;

    always_comb begin
        push_data.last     = (r_rd_pq == QUAD_W'(QUADS - 1));
        push_data.quadrant = r_rd_pq;
        push_data.entry    = old_entry;
    end

    sqa_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_rd_pend),
        .i_data  (push_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head),
        .o_count (q_count),
        .o_pop   (q_pop)
    );

    assign m_axis_tdata = OUT_DATA_W'(head.entry);
    assign m_axis_tuser = head.quadrant;
    assign m_axis_tlast = head.last;

    // the single ram read port is never claimed twice
    a_rd_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(info.take && rd_issue))
        else $error("frame and quadrant read share the ram read port");

    // returning ram data belongs to exactly one consumer
    a_rd_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_acc_vld && r_rd_pend))
        else $error("frame stage and quadrant read overlap");

    // credit check keeps the output queue from overflowing
    a_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ((q_count != QCNT_W'(OUTQ_DEPTH)) || q_pop))
        else $error("quadrant report pushed into a full queue");

    // clear wins over a write-back in the same cycle
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_clear |=> (r_valid == '0))
        else $error("valid bits survive a clear");

    // a read starts its sweep at quadrant zero and blocks the input
    a_read_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_read |=> (r_rd_busy && (r_rd_q == '0) && !s_axis_tready))
        else $error("read sweep did not start");

endmodule

`default_nettype wire

// ===== src/sqa_ram.sv =====
`default_nettype none

module sqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/sqa_piece.sv =====
`default_nettype none

module sqa_piece (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_begin,
    input  logic                       i_frame,
    input  logic [sqa_pkg::LEN_W-1:0]  i_length,
    input  logic [sqa_pkg::RND_W-1:0]  i_rounding,
    output sqa_pkg::t_frame_info       o_info
);

    import sqa_pkg::*;

    logic               r_active;
    logic [LEN_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_len;
    logic [BND_W-1:0]   r_thr;
    logic [BND_W-1:0]   r_bnd [PIECES-1];

    logic [LEN_W-1:0]   len_sat;
    logic [PIECES-2:0]  hit;
    logic [PIECE_W-1:0] piece;
    logic [LEN_W-1:0]   pos_inc;
    logic               take;

    always_comb begin
        if (32'(i_length) > MAX_LENGTH) begin
            len_sat = LEN_W'(MAX_LENGTH);
        end else begin
            len_sat = i_length;
        end
    end

    // boundary m is passed once rounding + (m+1)*len <= 12*pos + 11
    always_comb begin
        for (int m = 0; m < PIECES - 1; m++) begin
            hit[m] = (r_bnd[m] <= r_thr);
        end
    end

    assign piece   = PIECE_W'($countones(hit));
    assign take    = i_frame & r_active;
    assign pos_inc = r_pos + 1'b1;

    assign o_info.take     = take;
    assign o_info.quadrant = piece[QUAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_len    <= '0;
            r_thr    <= '0;
        end else if (i_begin) begin
            r_active <= (len_sat != '0);
            r_pos    <= '0;
            r_len    <= len_sat;
            r_thr    <= BND_W'(PIECES - 1);
        end else if (take) begin
            r_pos <= pos_inc;
            r_thr <= r_thr + BND_W'(PIECES);
            if (pos_inc >= r_len) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_begin) begin
            for (int m = 0; m < PIECES - 1; m++) begin
                r_bnd[m] <= BND_W'(i_rounding) + BND_W'(m + 1) * BND_W'(len_sat);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/sqa_outq.sv =====
`default_nettype none

module sqa_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  sqa_pkg::t_result            i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output sqa_pkg::t_result            o_data,
    output logic [sqa_pkg::QCNT_W-1:0]  o_count,
    output logic                        o_pop
);

    import sqa_pkg::*;

    t_result               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0]     r_count;
    logic [OUTQ_PTR_W-1:0] n_wr_ptr;
    logic [OUTQ_PTR_W-1:0] n_rd_ptr;

    assign o_valid = (r_count != '0);
    assign o_pop   = o_valid & i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (o_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, o_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_square_wave_quadrant_accumulator.sv =====
`default_nettype none

module tb_square_wave_quadrant_accumulator;
    import sqa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    // tracks the quadrant sums and counts and the reports a read will produce
    class quad_sum_tracker;
        logic [SUM_W-1:0] sums [QUADS][3];
        logic [CNT_W-1:0] counts [QUADS];
        int unsigned piece, position, bound_acc, next_bound, len_held;
        bit active;
        t_result reports_due[$];
        int unsigned errors;

        function new();
            zero_sums();
            piece = 0;
            position = 0;
            bound_acc = 0;
            next_bound = 0;
            len_held = 0;
            active = 1'b0;
            errors = 0;
        endfunction

        function void zero_sums();
            for (int q = 0; q < QUADS; q++) begin
                for (int c = 0; c < 3; c++) sums[q][c] = '0;
                counts[q] = '0;
            end
        endfunction

        // returns 0 only for a frame that lands outside an interval
        function bit take_command(t_action act, logic [LEN_W-1:0] len, logic [RND_W-1:0] rnd,
                                  logic [SAMPLE_W-1:0] sa, logic [SAMPLE_W-1:0] sb,
                                  logic [SAMPLE_W-1:0] sc);
            logic [SAMPLE_W-1:0] smp [3];
            int unsigned q;
            t_result r;
            smp[0] = sa;
            smp[1] = sb;
            smp[2] = sc;
            case (act)
                ACT_CLEAR: zero_sums();
                ACT_BEGIN: begin
                    len_held = (len > MAX_LENGTH) ? MAX_LENGTH : len;
                    piece = 0;
                    position = 0;
                    bound_acc = rnd + len_held;
                    next_bound = bound_acc / PIECES;
                    active = (len_held != 0);
                end
                ACT_FRAME: begin
                    if (!active) return 1'b0;
                    // empty pieces of a short interval are skipped in one go
                    while (piece < PIECES - 1 && position >= next_bound) begin
                        piece = piece + 1;
                        bound_acc = bound_acc + len_held;
                        next_bound = bound_acc / PIECES;
                    end
                    q = piece % QUADS;
                    for (int c = 0; c < 3; c++)
                        sums[q][c] = sums[q][c]
                                   + {{(SUM_W-SAMPLE_W){smp[c][SAMPLE_W-1]}}, smp[c]};
                    counts[q] = counts[q] + 1'b1;
                    position = position + 1;
                    if (position >= len_held) active = 1'b0;
                end
                ACT_READ: begin
                    for (int i = 0; i < QUADS; i++) begin
                        r.quadrant = QUAD_W'(i);
                        r.last = (i == QUADS - 1);
                        r.entry.sum_a = sums[i][0];
                        r.entry.sum_b = sums[i][1];
                        r.entry.sum_c = sums[i][2];
                        r.entry.frame_count = counts[i];
                        reports_due.push_back(r);
                    end
                end
            endcase
            return 1'b1;
        endfunction

        function void check_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_report(logic [QUAD_W-1:0] quad, logic [OUT_DATA_W-1:0] data,
                                   logic last);
            t_entry got;
            t_result want;
            got = data[ENTRY_W-1:0];
            if (reports_due.size() == 0) begin
                $error("quadrant report %0d arrived with no read pending", quad);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            check_field("quadrant", SUM_W'(want.quadrant), SUM_W'(quad));
            check_field("sum_a", want.entry.sum_a, got.sum_a);
            check_field("sum_b", want.entry.sum_b, got.sum_b);
            check_field("sum_c", want.entry.sum_c, got.sum_c);
            check_field("frame_count", SUM_W'(want.entry.frame_count),
                        SUM_W'(got.frame_count));
            check_field("last", SUM_W'(want.last), SUM_W'(last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // interval_length, rounding, sample_a, sample_b, sample_c, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // action
    logic [1:0]            s_axis_tuser = ACT_CLEAR;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // sum_a, sum_b, sum_c, frame_count
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // quadrant
    logic [QUAD_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    quad_sum_tracker board;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_counted = 0;
    int unsigned cycles = 0;

    square_wave_quadrant_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.match_report(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // drives one command transaction, returns at the falling edge after acceptance
    task automatic send_cmd(t_action act, logic [LEN_W-1:0] len, logic [RND_W-1:0] rnd,
                            logic [SAMPLE_W-1:0] sa, logic [SAMPLE_W-1:0] sb,
                            logic [SAMPLE_W-1:0] sc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= IN_DATA_W'({sc, sb, sa, rnd, len});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (board.take_command(act, len, rnd, sa, sb, sc)) items_counted++;
        @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_frame();
        send_cmd(ACT_FRAME, LEN_W'($urandom), RND_W'($urandom),
                 rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic send_plain(t_action act, int unsigned len, int unsigned rnd);
        send_cmd(act, LEN_W'(len), RND_W'(rnd), '0, '0, '0);
    endtask

    // begin an interval, feed it frames, then read the quadrants
    task automatic run_interval();
        int unsigned len, eff, feed, pick;
        pick = $urandom_range(99);
        if (pick < 65) len = $urandom_range(1, 30);
        else if (pick < 75) len = $urandom_range(31, 300);
        else if (pick < 80) len = 0;
        else if (pick < 88) len = $urandom_range(MAX_LENGTH + 1, 8191);
        else len = $urandom_range(8191);
        eff = (len > MAX_LENGTH) ? MAX_LENGTH : len;
        if (eff > 30) feed = $urandom_range(1, 24);   // abandoned by the next begin
        else begin
            pick = $urandom_range(99);
            if (pick < 75) feed = eff;
            else if (pick < 88) feed = eff + $urandom_range(1, 3);
            else feed = $urandom_range(eff);
        end
        if ($urandom_range(99) < 6) send_plain(ACT_CLEAR, $urandom, $urandom);
        send_plain(ACT_BEGIN, len, $urandom_range(15));
        repeat (feed) begin
            send_frame();
            if ($urandom_range(99) < 4) send_plain(ACT_READ, $urandom, $urandom);
        end
        if ($urandom_range(99) < 90) send_plain(ACT_READ, $urandom, $urandom);
    endtask

    task automatic run_phase(int unsigned budget);
        int unsigned stop_at;
        stop_at = items_counted + budget;
        while (items_counted < stop_at) begin
            if ($urandom_range(99) < 12)
                send_cmd(t_action'($urandom_range(3)), LEN_W'($urandom), RND_W'($urandom),
                         rand_sample(), rand_sample(), rand_sample());
            else
                run_interval();
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (board.reports_due.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        board = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset values, ignored frames, extremes, short and odd intervals
        send_plain(ACT_READ, 0, 0);
        send_cmd(ACT_FRAME, '1, '1, 16'h7fff, 16'h8000, 16'hffff);
        send_plain(ACT_BEGIN, 5, 0);
        send_cmd(ACT_FRAME, '0, '0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_cmd(ACT_FRAME, '0, '0, 16'h8000, 16'h8000, 16'h8000);
        send_cmd(ACT_FRAME, '0, '0, 16'hffff, 16'h0000, 16'h0001);
        send_cmd(ACT_FRAME, '0, '0, 16'h5555, 16'haaaa, 16'h8000);
        send_cmd(ACT_FRAME, '0, '0, 16'haaaa, 16'h5555, 16'h7fff);
        send_cmd(ACT_FRAME, '0, '0, 16'h1234, 16'h1234, 16'h1234);
        send_plain(ACT_READ, 0, 0);
        // short interval with rounding above eleven
        send_plain(ACT_BEGIN, 3, 15);
        repeat (3) send_frame();
        // zero length keeps the interval closed
        send_plain(ACT_BEGIN, 0, 11);
        send_frame();
        // oversize length saturates, then a new begin abandons it
        send_plain(ACT_BEGIN, 8191, 7);
        send_frame();
        send_plain(ACT_BEGIN, 12, 0);
        send_frame();
        send_plain(ACT_READ, 0, 0);
        send_plain(ACT_CLEAR, 0, 0);
        send_plain(ACT_READ, 0, 0);

        send_idle_pct = 8;
        recv_idle_pct = 69;
        run_phase(150);
        hold_until_drained();

        send_idle_pct = 69;
        recv_idle_pct = 8;
        run_phase(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(150);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
